[sv/assert_macros.svh]
// Assertion macros shared by the polynomial term accumulator RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define ASSERT_IMPL(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[sv/pta_pkg.sv]
// Package for the polynomial term accumulator: field widths, request codes
// and controller states. No dependencies.
`timescale 1ns / 1ps
package pta_pkg;

  localparam int REQ_W     = 2;
  localparam int TCOEFF_W  = 32;
  localparam int EXP_W     = 6;
  localparam int POINT_W   = 32;
  localparam int VALUE_W   = 32;
  localparam int TCOUNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_EVAL   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_EV_RUN,
    ST_EV_LAST,
    ST_RESP
  } state_t;

endpackage

[sv/pta_ifs.sv]
// Request and response channel interfaces (valid/ready) for the polynomial
// term accumulator. Depends on pta_pkg.
`timescale 1ns / 1ps
interface pta_req_if;
  import pta_pkg::*;
  logic                       valid;
  logic                       ready;
  logic        [REQ_W-1:0]    req_type;
  logic signed [TCOEFF_W-1:0] term_coeff;
  logic        [EXP_W-1:0]    term_exp;
  logic signed [POINT_W-1:0]  point;

  modport source (output valid, req_type, term_coeff, term_exp, point, input ready);
  modport sink   (input valid, req_type, term_coeff, term_exp, point, output ready);
endinterface

interface pta_rsp_if;
  import pta_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  logic        [TCOUNT_W-1:0] term_count;

  modport source (output valid, value, term_count, input ready);
  modport sink   (input valid, value, term_count, output ready);
endinterface

[sv/pta_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
`timescale 1ns / 1ps
module pta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/polynomial_term_accumulator_core.sv]
// Polynomial term accumulator top level: dense coefficient store in a RAM,
// read-modify-write insert, Horner evaluate. Depends on pta_pkg, pta_ifs,
// pta_ram and assert_macros.svh.
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------
//   req     | in  | req_type, term_coeff, term_exp, point
//   rsp     | out | value (evaluate result, else 0), term_count
//
// Accepted beat to loaded response: insert passes a RAM read and a write
// state (neither when the exponent is out of range or the coefficient is
// zero), clear and unused codes go straight to response, and evaluate does
// one read and multiply-add per coefficient; beats are taken only in idle.
// Reset clears at once: every entry has a valid bit, and an entry whose bit
// is clear reads as zero, so no clearing pass is needed. A clear request
// drops all valid bits at once.
// A response that is not taken stalls the controller in its response state
// only; the next request beat is still taken while the response waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polynomial_term_accumulator_core #(
  parameter int MAX_DEGREE  = 63,
  parameter int COEFF_WIDTH = 32
) (
  input logic     clk,
  input logic     rst,
  pta_req_if.sink   req,
  pta_rsp_if.source rsp
);
  import pta_pkg::*;

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // controller
  state_t state, state_next;

  // control registers (reset)
  logic [DEPTH-1:0] vld;         // entry written since last clear
  logic [CNT_W-1:0] cnt;         // nonzero terms
  logic             out_valid;

  // payload registers (no reset)
  logic [AW-1:0]          exp_q;
  logic [COEFF_WIDTH-1:0] add_q;
  logic [VALUE_W-1:0]     x_q;
  logic [VALUE_W-1:0]     acc;
  logic [AW-1:0]          idx;
  logic                   pend;   // rdata holds a coefficient for Horner
  logic                   vld_q;  // valid bit of the entry in rdata
  logic [VALUE_W-1:0]     out_value;
  logic [TCOUNT_W-1:0]    out_count;

  // RAM ports
  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [COEFF_WIDTH-1:0] ram_wdata;
  logic [COEFF_WIDTH-1:0] ram_rdata;

  // decoded beat
  logic                   req_fire;
  logic                   rsp_fire;
  logic                   out_free;
  logic                   resp_load;
  req_code_t              code;
  logic [COEFF_WIDTH-1:0] add_in;
  logic                   ins_ok;

  // datapath
  logic [COEFF_WIDTH-1:0] old_coef;
  logic [COEFF_WIDTH-1:0] sum;
  logic [VALUE_W-1:0]     coef_term;
  logic [VALUE_W-1:0]     mac;

  pta_ram #(
    .WIDTH (COEFF_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (exp_q),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = out_valid && rsp.ready;
  assign out_free = !out_valid || rsp.ready;
  assign code     = req_code_t'(req.req_type);

  // coefficient sign-extended or truncated to the store width
  assign add_in = COEFF_WIDTH'(req.term_coeff);
  assign ins_ok = (int'(req.term_exp) <= MAX_DEGREE) && (add_in != '0);

  // insert read-modify-write; an entry not written since clear is zero
  assign old_coef  = vld_q ? ram_rdata : '0;
  assign sum       = old_coef + add_q;
  assign ram_wdata = sum;

  // Horner step: acc * x + coefficient, all modulo 2^32
  assign coef_term = (pend && vld_q) ? VALUE_W'($signed(ram_rdata)) : '0;
  assign mac       = acc * x_q + coef_term;

  // controller outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    ram_we    = (state == ST_INS_WR);
    ram_raddr = (state == ST_EV_RUN) ? idx : exp_q;
    resp_load = (state == ST_RESP) && out_free;
  end

  // controller next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (code)
            REQ_INSERT: state_next = ins_ok ? ST_INS_RD : ST_RESP;
            REQ_EVAL:   state_next = ST_EV_RUN;
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_INS_RD:  state_next = ST_INS_WR;
      ST_INS_WR:  state_next = ST_RESP;
      ST_EV_RUN:  state_next = (idx == '0) ? ST_EV_LAST : ST_EV_RUN;
      ST_EV_LAST: state_next = ST_RESP;
      ST_RESP:    state_next = out_free ? ST_IDLE : ST_RESP;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire && code == REQ_CLEAR) begin
        vld <= '0;
        cnt <= '0;
      end
      if (state == ST_INS_WR) begin
        vld[exp_q] <= 1'b1;
        // count follows the zero/nonzero transition of the entry
        if (old_coef == '0 && sum != '0) begin
          cnt <= cnt + CNT_W'(1);
        end else if (old_coef != '0 && sum == '0) begin
          cnt <= cnt - CNT_W'(1);
        end
      end
      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (rsp_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    vld_q <= vld[ram_raddr];
    pend  <= (state == ST_EV_RUN);
    if (req_fire) begin
      exp_q <= AW'(req.term_exp);
      add_q <= add_in;
      x_q   <= VALUE_W'(req.point);
      idx   <= AW'(DEPTH - 1);
      acc   <= '0;
    end
    if (state == ST_EV_RUN) begin
      idx <= idx - AW'(1);
    end
    if (state == ST_EV_RUN || state == ST_EV_LAST) begin
      acc <= mac;
    end
    if (resp_load) begin
      out_value <= acc;
      out_count <= TCOUNT_W'(cnt);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.value      = out_value;
  assign rsp.term_count = out_count;

  // never more nonzero terms than entries
  `ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, int'(cnt) <= DEPTH)
  // an accepted beat closes the request side until the response is queued
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_fire, !req.ready)
  // a written entry is marked valid from then on
  `ASSERT_NEXT(a_write_marks_valid, clk, rst, ram_we, vld[$past(exp_q)])
  // the last coefficient read leads straight into the final Horner step
  `ASSERT_NEXT(a_eval_tail, clk, rst, state == ST_EV_RUN && idx == '0,
               state == ST_EV_LAST)
  // a response loaded from the response state shows up on the port
  `ASSERT_NEXT(a_resp_shown, clk, rst, resp_load, rsp.valid)

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for polynomial_term_accumulator_core: directed and
// random insert, evaluate and clear beats are checked against an in-bench model.
// Depends on pta_pkg, pta_ifs and the core RTL.
module testbench;
  import pta_pkg::*;

  localparam int MAX_DEG = 63;
  localparam int DEPTH = MAX_DEG + 1;
  localparam int COEFF_W = 32;
  // Request code with no operation behind it; the block answers it as a no-op.
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int RANDOM_BEATS = 480;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = MAX_DEG + 20;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [TCOUNT_W-1:0] term_count;
  } poly_result_t;

  // Polynomial model: dense coefficient store, nonzero count and the queue of
  // responses the block still owes.
  class poly_scoreboard;
    logic [COEFF_W-1:0] coeff_mem [DEPTH];
    int unsigned nonzero;
    poly_result_t result_q[$];
    int unsigned errors, checked;
    int unsigned n_ins, n_eval, n_clear, n_spare, n_cancel, peak_terms;

    function new();
      wipe();
      errors = 0;
      checked = 0;
      n_ins = 0;
      n_eval = 0;
      n_clear = 0;
      n_spare = 0;
      n_cancel = 0;
      peak_terms = 0;
    endfunction

    function void wipe();
      foreach (coeff_mem[i]) coeff_mem[i] = '0;
      nonzero = 0;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [TCOEFF_W-1:0] coeff,
                               logic [EXP_W-1:0] e, logic [POINT_W-1:0] x);
      poly_result_t r;
      logic [COEFF_W-1:0] sum;
      logic [VALUE_W-1:0] acc;
      int i;
      r.value = '0;
      case (kind)
        REQ_INSERT: begin
          n_ins++;
          if (coeff != '0 && e <= MAX_DEG) begin
            sum = coeff_mem[e] + coeff;
            if (coeff_mem[e] == '0) begin
              nonzero++;
            end else if (sum == '0) begin
              nonzero--;
              n_cancel++;
            end
            coeff_mem[e] = sum;
          end
        end
        REQ_EVAL: begin
          n_eval++;
          // Horner from the top exponent down; 32-bit wrap throughout.
          acc = '0;
          for (i = DEPTH - 1; i >= 0; i--) acc = acc * x + coeff_mem[i];
          r.value = acc;
        end
        REQ_CLEAR: begin
          n_clear++;
          wipe();
        end
        default: n_spare++;
      endcase
      if (nonzero > peak_terms) peak_terms = nonzero;
      r.term_count = nonzero[TCOUNT_W-1:0];
      result_q.push_back(r);
    endfunction

    function void check_response(logic [VALUE_W-1:0] value, logic [TCOUNT_W-1:0] count);
      poly_result_t want;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual value %h term_count %0d",
                 $time, value, count);
        errors++;
        return;
      end
      want = result_q.pop_front();
      checked++;
      if (value !== want.value) begin
        $display("%0t: value mismatch: expected %h, actual %h", $time, want.value, value);
        errors++;
      end
      if (count !== want.term_count) begin
        $display("%0t: term_count mismatch: expected %0d, actual %0d",
                 $time, want.term_count, count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycle_cnt = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;
  int unsigned stall_left = 0;

  pta_req_if req_ch ();
  pta_rsp_if rsp_ch ();

  polynomial_term_accumulator_core #(
    .MAX_DEGREE (MAX_DEG),
    .COEFF_WIDTH(COEFF_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  poly_scoreboard sb = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timeout guard: a run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_cnt, sb.result_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Monitor: note every accepted request beat, check every accepted response
  // beat. Both sample the values that stood before this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.req_type, req_ch.term_coeff, req_ch.term_exp, req_ch.point);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.value, rsp_ch.term_count);
    end
  end

  // Response sink: random stall bursts, one long hold-off on request, and no
  // random bursts at all while quiet is set.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (rst || stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        if (stall_left != 0) stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request beat and hold it until it is taken. Afterwards, drop
  // valid for a random burst now and then unless quiet is set. Valid stays
  // high across back-to-back beats, so it gets one assignment per step.
  task automatic send_beat(logic [REQ_W-1:0] kind, logic [TCOEFF_W-1:0] coeff,
                           logic [EXP_W-1:0] e, logic [POINT_W-1:0] x);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.term_coeff <= coeff;
    req_ch.term_exp   <= e;
    req_ch.point      <= x;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed response has been taken.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TCOEFF_W-1:0] pick_coeff(logic [EXP_W-1:0] e);
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 20) - 10;
      2: return -sb.coeff_mem[e];   // cancel the term at this exponent
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POINT_W-1:0] pick_point();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom_range(0, 6) - 3;
      3: begin
        case ($urandom_range(0, 2))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Well-formed sequence: clear, fill every exponent, evaluate the full
  // polynomial.
  task automatic fill_and_evaluate();
    logic [TCOEFF_W-1:0] c;
    send_beat(REQ_CLEAR, $urandom(), EXP_W'($urandom()), $urandom());
    for (int e = 0; e < DEPTH; e++) begin
      c = $urandom();
      if (c == '0) c = 32'd1;
      send_beat(REQ_INSERT, c, e[EXP_W-1:0], $urandom());
    end
    send_beat(REQ_EVAL, $urandom(), EXP_W'($urandom()), pick_point());
  endtask

  initial begin
    int unsigned pick;
    logic [EXP_W-1:0] e;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_INSERT;
    req_ch.term_coeff <= '0;
    req_ch.term_exp   <= '0;
    req_ch.point      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, zero insert, coefficient wrap, sums that cancel,
    // extreme exponents and points, the unused code, and clear.
    send_beat(REQ_EVAL,   32'h0, 6'd0,  32'h0000_0000);
    send_beat(REQ_INSERT, 32'h0, 6'd5,  32'h0);
    send_beat(REQ_INSERT, 32'h7FFF_FFFF, 6'd0,  32'h0);
    send_beat(REQ_INSERT, 32'h0000_0001, 6'd0,  32'h0);
    send_beat(REQ_INSERT, 32'h8000_0000, 6'd63, 32'h0);
    send_beat(REQ_EVAL,   32'h0, 6'd0,  32'h0000_0000);
    send_beat(REQ_EVAL,   32'h0, 6'd0,  32'h0000_0001);
    send_beat(REQ_EVAL,   32'h0, 6'd0,  32'hFFFF_FFFF);
    send_beat(REQ_INSERT, 32'h8000_0000, 6'd63, 32'h0);
    send_beat(REQ_INSERT, 32'h0000_0005, 6'd1,  32'h0);
    send_beat(REQ_INSERT, 32'hFFFF_FFFB, 6'd1,  32'h0);
    send_beat(REQ_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h0);
    send_beat(REQ_INSERT, 32'h0000_0003, 6'd31, 32'h0);
    send_beat(REQ_EVAL,   32'h0, 6'd0,  32'h7FFF_FFFF);
    send_beat(REQ_EVAL,   32'h0, 6'd0,  32'h8000_0000);
    send_beat(REQ_SPARE,  32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    send_beat(REQ_SPARE,  32'h0, 6'd0,  32'h0);
    send_beat(REQ_CLEAR,  32'h0, 6'd0,  32'h0);
    send_beat(REQ_EVAL,   32'h0, 6'd0,  32'h0000_0002);
    send_beat(REQ_INSERT, 32'h8000_0000, 6'd0,  32'h0);
    send_beat(REQ_EVAL,   32'h0, 6'd0,  $urandom());
    send_beat(REQ_CLEAR,  32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);

    // Random mix, with two full-store sequences, one long response hold-off,
    // one full drain, and quiet stretches with no idling on either side.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      quiet = (n >= 250 && n < 300) || n >= 400;
      if (n == 100 || n == 350) fill_and_evaluate();
      if (n == 150) hold_req = 1'b1;
      if (n == 320) drain();
      pick = $urandom_range(0, 99);
      e = EXP_W'($urandom_range(0, MAX_DEG));
      if (pick < 60)
        send_beat(REQ_INSERT, pick_coeff(e), e, $urandom());
      else if (pick < 90)
        send_beat(REQ_EVAL, $urandom(), EXP_W'($urandom()), pick_point());
      else if (pick < 93)
        send_beat(REQ_CLEAR, $urandom(), EXP_W'($urandom()), $urandom());
      else
        send_beat(REQ_SPARE, $urandom(), EXP_W'($urandom()), $urandom());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d summed to zero), %0d evaluates, %0d clears, %0d %s",
             sb.n_ins, sb.n_cancel, sb.n_eval, sb.n_clear, sb.n_spare, "unused codes");
    $display("peak of %0d nonzero terms; %0d responses checked, %0d errors",
             sb.peak_terms, sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
